@@ rtl/core/sgb_pkg.sv @@
// Shared types and constants of the separable Gaussian blur.
`timescale 1ns / 1ps
`default_nettype none
package sgb_pkg;
    localparam int MaxRows   = 256;
    localparam int MaxCols   = 256;
    localparam int MaxRadius = 4;
    localparam int PixelBits = 16;
    localparam int TapCount  = 5;
    localparam int RowBits   = $clog2(MaxRows);
    localparam int ColBits   = $clog2(MaxCols);
    localparam int AddrBits  = RowBits + ColBits;
    localparam int DimBits   = RowBits + 1;
    localparam int InterBits = PixelBits + 8;
    localparam int TapBits   = 16;
    localparam int RadBits   = 3;
    localparam int AccBits   = InterBits + TapBits + 4;

    typedef enum logic [2:0]
    {
        CFG_ROWS  = 3'd0,
        CFG_COLS  = 3'd1,
        CFG_RAD   = 3'd2,
        CFG_TAP0  = 3'd3,
        CFG_TAP1  = 3'd4,
        CFG_TAP2  = 3'd5,
        CFG_TAP3  = 3'd6,
        CFG_TAP4  = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_HMAC,
        ST_HDRAIN,
        ST_VMAC,
        ST_VDRAIN
    } state_t;

    // controller to datapath
    typedef struct packed
    {
        logic load;       // write pixel, advance load counters
        logic h_start;    // clear accumulator, tap index to -radius, column 0
        logic v_start;    // clear accumulator for vertical pass
        logic mac_issue;  // issue one read for current tap
        logic tap_adv;    // advance tap index
        logic h_col_adv;  // next column, restart taps
        logic h_write;    // store horizontal result
        logic v_emit;     // present vertical result
    } cmd_t;

    // datapath to controller
    typedef struct packed
    {
        logic frame_ready;
        logic row_done;   // load filled the row
        logic tap_last;   // current tap is the last
        logic col_last;   // current horizontal column is the last
        logic acc_done;   // pipeline has drained the last product
    } stat_t;
endpackage
`default_nettype wire

@@ rtl/core/sgb_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module sgb_ram #(
    parameter int Width = 16,
    parameter int Depth = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/core/sgb_ctrl.sv @@
// Controller state machine of the blur.
`timescale 1ns / 1ps
`default_nettype none
module sgb_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          kind,
    input  wire sgb_pkg::stat_t stat,
    output logic               busy,
    output sgb_pkg::cmd_t      cmd
);
    sgb_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sgb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    logic go;
    assign go = start && (state_reg == sgb_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sgb_pkg::ST_IDLE:
            begin
                if (go && !kind && !stat.frame_ready && stat.row_done)
                begin
                    state_next = sgb_pkg::ST_HMAC;
                end
                else if (go && kind && stat.frame_ready)
                begin
                    state_next = sgb_pkg::ST_VMAC;
                end
            end
            sgb_pkg::ST_HMAC:
            begin
                if (stat.tap_last)
                begin
                    state_next = sgb_pkg::ST_HDRAIN;
                end
            end
            sgb_pkg::ST_HDRAIN:
            begin
                if (stat.acc_done)
                begin
                    state_next = stat.col_last ? sgb_pkg::ST_IDLE : sgb_pkg::ST_HMAC;
                end
            end
            sgb_pkg::ST_VMAC:
            begin
                if (stat.tap_last)
                begin
                    state_next = sgb_pkg::ST_VDRAIN;
                end
            end
            sgb_pkg::ST_VDRAIN:
            begin
                if (stat.acc_done)
                begin
                    state_next = sgb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sgb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != sgb_pkg::ST_IDLE);
        unique case (state_reg)
            sgb_pkg::ST_IDLE:
            begin
                cmd.load    = go && !kind && !stat.frame_ready;
                cmd.h_start = go && !kind && !stat.frame_ready && stat.row_done;
                cmd.v_start = go && kind && stat.frame_ready;
            end
            sgb_pkg::ST_HMAC, sgb_pkg::ST_VMAC:
            begin
                cmd.mac_issue = 1'b1;
                cmd.tap_adv   = !stat.tap_last;
            end
            sgb_pkg::ST_HDRAIN:
            begin
                cmd.h_write   = stat.acc_done;
                cmd.h_col_adv = stat.acc_done && !stat.col_last;
            end
            sgb_pkg::ST_VDRAIN:
            begin
                cmd.v_emit = stat.acc_done;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // a pass never starts while another is running
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !(cmd.h_start || cmd.v_start || cmd.load))
        else $error("start command while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.v_emit |=> state_reg == sgb_pkg::ST_IDLE)
        else $error("result not followed by idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.h_start |=> state_reg == sgb_pkg::ST_HMAC)
        else $error("row pass did not begin");
endmodule
`default_nettype wire

@@ rtl/core/sgb_dp.sv @@
// Datapath of the blur: counters, stores, mirror addressing and one MAC.
`timescale 1ns / 1ps
`default_nettype none
module sgb_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [sgb_pkg::PixelBits-1:0]  pixel,
    input  wire logic [8:0]                     image_rows,
    input  wire logic [8:0]                     image_cols,
    input  wire logic [2:0]                     kernel_radius,
    input  wire logic [sgb_pkg::TapCount*16-1:0] taps,
    input  wire sgb_pkg::cmd_t                  cmd,
    output sgb_pkg::stat_t                      stat,
    output logic                                result_valid,
    output logic [sgb_pkg::PixelBits-1:0]       blurred,
    output logic                                last
);
    localparam int RB = sgb_pkg::RowBits;
    localparam int CB = sgb_pkg::ColBits;
    localparam int DB = sgb_pkg::DimBits;
    localparam int IB = sgb_pkg::InterBits;
    localparam int AB = sgb_pkg::AccBits;

    // live dimensions
    logic [DB-1:0] rows, cols;
    always_comb
    begin
        if (image_rows == 9'd0)
            rows = DB'(1);
        else if ({{(DB+1){1'b0}}, image_rows} > (DB+10)'(sgb_pkg::MaxRows))
            rows = DB'(sgb_pkg::MaxRows);
        else
            rows = DB'(image_rows);
        if (image_cols == 9'd0)
            cols = DB'(1);
        else if ({{(DB+1){1'b0}}, image_cols} > (DB+10)'(sgb_pkg::MaxCols))
            cols = DB'(sgb_pkg::MaxCols);
        else
            cols = DB'(image_cols);
    end

    function automatic logic [3:0] clamp_rad(input logic [2:0] r, input logic [DB-1:0] dim);
        logic [3:0] v;
        v = {1'b0, r};
        if (v > 4'(sgb_pkg::MaxRadius))
            v = 4'(sgb_pkg::MaxRadius);
        if (v > 4'(sgb_pkg::TapCount - 1))
            v = 4'(sgb_pkg::TapCount - 1);
        if ({{DB{1'b0}}, v} > {4'd0, dim - DB'(1)})
            v = 4'(dim - DB'(1));
        return v;
    endfunction

    // mirror with clamp; p is signed position
    function automatic logic [DB-1:0] mirror(input logic signed [DB+1:0] p,
                                             input logic [DB-1:0] dim);
        logic signed [DB+1:0] q, d;
        d = $signed({2'b00, dim});
        q = (p < 0) ? -p : p;
        if (q >= d)
            q = (d <<< 1) - (DB+2)'(2) - q;
        if (q < 0)
            q = '0;
        if (q >= d)
            q = d - (DB+2)'(1);
        return q[DB-1:0];
    endfunction

    logic [DB-1:0] load_row_reg, load_col_reg, fetch_row_reg, fetch_col_reg;
    logic          ready_reg;
    logic [DB-1:0] lrow, lcol, frow, fcol;
    assign lrow = (load_row_reg >= rows) ? rows - DB'(1) : load_row_reg;
    assign lcol = (load_col_reg >= cols) ? cols - DB'(1) : load_col_reg;
    assign frow = (fetch_row_reg >= rows) ? rows - DB'(1) : fetch_row_reg;
    assign fcol = (fetch_col_reg >= cols) ? cols - DB'(1) : fetch_col_reg;

    // pass context
    logic                 vert_reg;
    logic [RB-1:0]        prow_reg;   // row of horizontal pass
    logic [DB-1:0]        pcol_reg;   // column being computed
    logic [RB-1:0]        vrow_reg;
    logic [CB-1:0]        vcol_reg;
    logic                 vlast_reg;
    logic [3:0]           rad_reg;
    logic signed [4:0]    k_reg;
    logic [DB-1:0]        pdim_reg;

    logic [3:0] hrad, vrad;
    assign hrad = clamp_rad(kernel_radius, cols);
    assign vrad = clamp_rad(kernel_radius, rows);

    assign stat.frame_ready = ready_reg;
    assign stat.row_done    = (lcol + DB'(1)) >= cols;
    assign stat.tap_last    = (k_reg == $signed({1'b0, rad_reg}));
    assign stat.col_last    = (pcol_reg + DB'(1)) >= pdim_reg;

    // read address
    logic [DB-1:0] mpos;
    logic signed [DB+1:0] spos;
    always_comb
    begin
        if (vert_reg)
            spos = $signed({2'b00, DB'(vrow_reg)}) + (DB+2)'(k_reg);
        else
            spos = $signed({2'b00, pcol_reg}) + (DB+2)'(k_reg);
        mpos = mirror(spos, vert_reg ? rows : cols);
    end

    logic [sgb_pkg::AddrBits-1:0] f_raddr, r_raddr, f_waddr, r_waddr;
    assign f_raddr = {prow_reg, mpos[CB-1:0]};
    assign r_raddr = {mpos[RB-1:0], vcol_reg};
    assign f_waddr = {lrow[RB-1:0], lcol[CB-1:0]};
    assign r_waddr = {prow_reg, pcol_reg[CB-1:0]};

    logic [sgb_pkg::PixelBits-1:0] f_rdata;
    logic [IB-1:0]                 r_rdata, h_val;

    sgb_ram #(.Width(sgb_pkg::PixelBits), .Depth(sgb_pkg::MaxRows * sgb_pkg::MaxCols))
    u_frame (
        .clk(clk), .we(cmd.load), .waddr(f_waddr), .wdata(pixel),
        .raddr(f_raddr), .rdata(f_rdata)
    );
    sgb_ram #(.Width(IB), .Depth(sgb_pkg::MaxRows * sgb_pkg::MaxCols))
    u_rowpass (
        .clk(clk), .we(cmd.h_write), .waddr(r_waddr), .wdata(h_val),
        .raddr(r_raddr), .rdata(r_rdata)
    );

    // tap selection, delayed with the read
    logic [3:0]  absk;
    logic [15:0] tap_sel, tap_d_reg;
    logic        iss_d_reg, iss_dd_reg, vert_d_reg;
    assign absk = k_reg[4] ? 4'(-k_reg) : k_reg[3:0];
    always_comb
    begin
        tap_sel = taps[15:0];
        for (int i = 0; i < sgb_pkg::TapCount; i++)
        begin
            if (absk == 4'(i))
                tap_sel = taps[i*16 +: 16];
        end
    end

    logic [IB-1:0]       mul_a;
    logic [IB+15:0]      prod_reg;
    logic [AB-1:0]       acc_reg;
    assign mul_a = vert_d_reg ? r_rdata : {8'd0, f_rdata};

    assign stat.acc_done = !iss_d_reg && !iss_dd_reg;

    always_ff @(posedge clk)
    begin
        tap_d_reg  <= tap_sel;
        vert_d_reg <= vert_reg;
        prod_reg   <= mul_a * tap_d_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_d_reg  <= 1'b0;
            iss_dd_reg <= 1'b0;
        end
        else
        begin
            iss_d_reg  <= cmd.mac_issue;
            iss_dd_reg <= iss_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.h_start || cmd.v_start || cmd.h_col_adv)
            acc_reg <= '0;
        else if (iss_dd_reg)
            acc_reg <= acc_reg + AB'(prod_reg);
    end

    // rounding
    logic [AB-1:0] h_rnd, v_rnd;
    assign h_rnd = (acc_reg + AB'(64)) >> 7;
    assign v_rnd = (acc_reg + (AB'(1) << 22)) >> 23;
    assign h_val = (h_rnd > AB'({IB{1'b1}})) ? {IB{1'b1}} : h_rnd[IB-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.h_start)
        begin
            vert_reg <= 1'b0;
            prow_reg <= lrow[RB-1:0];
            pcol_reg <= '0;
            pdim_reg <= cols;
            rad_reg  <= hrad;
            k_reg    <= -$signed({1'b0, hrad});
        end
        else if (cmd.v_start)
        begin
            vert_reg <= 1'b1;
            vrow_reg <= frow[RB-1:0];
            vcol_reg <= fcol[CB-1:0];
            rad_reg  <= vrad;
            k_reg    <= -$signed({1'b0, vrad});
        end
        else if (cmd.h_col_adv)
        begin
            pcol_reg <= pcol_reg + DB'(1);
            k_reg    <= -$signed({1'b0, rad_reg});
        end
        else if (cmd.tap_adv)
        begin
            k_reg <= k_reg + 5'sd1;
        end
        if (cmd.v_emit)
        begin
            blurred <= (v_rnd > AB'({sgb_pkg::PixelBits{1'b1}}))
                       ? {sgb_pkg::PixelBits{1'b1}} : v_rnd[sgb_pkg::PixelBits-1:0];
            last    <= vlast_reg;
        end
    end

    // counters and frame flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_row_reg  <= '0;
            load_col_reg  <= '0;
            fetch_row_reg <= '0;
            fetch_col_reg <= '0;
            ready_reg     <= 1'b0;
            vlast_reg     <= 1'b0;
            result_valid  <= 1'b0;
        end
        else
        begin
            result_valid <= cmd.v_emit;
            if (cmd.load)
            begin
                if (stat.row_done)
                begin
                    load_col_reg <= '0;
                    if (lrow + DB'(1) >= rows)
                    begin
                        load_row_reg <= '0;
                        ready_reg    <= 1'b1;
                    end
                    else
                        load_row_reg <= lrow + DB'(1);
                end
                else
                begin
                    load_row_reg <= lrow;
                    load_col_reg <= lcol + DB'(1);
                end
            end
            if (cmd.v_start)
            begin
                vlast_reg <= 1'b0;
                if (fcol + DB'(1) >= cols)
                begin
                    fetch_col_reg <= '0;
                    if (frow + DB'(1) >= rows)
                    begin
                        vlast_reg     <= 1'b1;
                        fetch_row_reg <= '0;
                        load_row_reg  <= '0;
                        load_col_reg  <= '0;
                        ready_reg     <= 1'b0;
                    end
                    else
                        fetch_row_reg <= frow + DB'(1);
                end
                else
                begin
                    fetch_row_reg <= frow;
                    fetch_col_reg <= fcol + DB'(1);
                end
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.h_write |-> !vert_reg)
        else $error("row store written during column pass");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !ready_reg)
        else $error("load taken while frame ready");
    assert property (@(posedge clk) disable iff (!rst_n)
        iss_dd_reg |-> $past(cmd.mac_issue, 2))
        else $error("product without issue");
endmodule
`default_nettype wire

@@ rtl/core/separable_gaussian_blur_2d.sv @@
// Top level of the separable Gaussian blur with mirror boundaries.
//
// Usage:
//  Items enter on start/kind/pixel, taken at an edge where start is high and
//  busy is low. kind 0 loads the next raster pixel; kind 1 fetches the next
//  filtered pixel. A fetch result appears on blurred/last for one cycle with
//  result_valid high; the receiver cannot stall it.
//  Registers are written on cfg_valid/cfg_ready with cfg_index/cfg_data, and
//  are accepted in every cycle; write them only while the block is idle.
// Passes:
//  A load that does not end a row leaves busy low. A load that ends a row
//  holds busy for the row pass: per column 2r+1 frame store reads, a
//  pipeline drain and a row store write, r being the radius clamped to 4
//  and to cols-1. A fetch holds busy for 2r+1 row store reads and the
//  drain, r clamped to 4 and to rows-1; result_valid rises in the first
//  cycle with busy low again, so the next item can be taken in that same
//  cycle. Loads while a frame is ready and fetches before it give nothing.
// Reset:
//  rst_n clears counters, the frame flag and the registers to their reset
//  values. The stores hold no reset and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module separable_gaussian_blur_2d (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        kind,
    input  wire logic [15:0] pixel,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    output logic             result_valid,
    output logic [15:0]      blurred,
    output logic             last
);
    logic [8:0]  rows_reg, cols_reg;
    logic [2:0]  rad_reg;
    logic [sgb_pkg::TapCount*16-1:0] taps_reg;

    assign cfg_ready = 1'b1;

    // hold register values; the pass reads them live
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= 9'd256;
            cols_reg <= 9'd256;
            rad_reg  <= 3'd0;
            taps_reg <= {{(sgb_pkg::TapCount-1)*16{1'b0}}, 16'd32768};
        end
        else if (cfg_valid)
        begin
            unique case (sgb_pkg::cfg_idx_t'(cfg_index))
                sgb_pkg::CFG_ROWS: rows_reg <= cfg_data[8:0];
                sgb_pkg::CFG_COLS: cols_reg <= cfg_data[8:0];
                sgb_pkg::CFG_RAD:  rad_reg  <= cfg_data[2:0];
                sgb_pkg::CFG_TAP0: taps_reg[0*16 +: 16] <= cfg_data;
                sgb_pkg::CFG_TAP1: taps_reg[1*16 +: 16] <= cfg_data;
                sgb_pkg::CFG_TAP2: taps_reg[2*16 +: 16] <= cfg_data;
                sgb_pkg::CFG_TAP3: taps_reg[3*16 +: 16] <= cfg_data;
                sgb_pkg::CFG_TAP4: taps_reg[4*16 +: 16] <= cfg_data;
                default: rows_reg <= rows_reg;
            endcase
        end
    end

    sgb_pkg::cmd_t  cmd;
    sgb_pkg::stat_t stat;

    sgb_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .kind(kind),
        .stat(stat), .busy(busy), .cmd(cmd)
    );

    sgb_dp u_dp (
        .clk(clk), .rst_n(rst_n), .pixel(pixel),
        .image_rows(rows_reg), .image_cols(cols_reg), .kernel_radius(rad_reg),
        .taps(taps_reg), .cmd(cmd), .stat(stat),
        .result_valid(result_valid), .blurred(blurred), .last(last)
    );

    // a result only follows a fetch that found the frame ready
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !kind) |=> !result_valid)
        else $error("result after a load");
endmodule
`default_nettype wire

@@ bench/separable_gaussian_blur_2d_checker.sv @@
// Checker that predicts and compares the blurred pixels of the block.
`timescale 1ns / 1ps
module separable_gaussian_blur_2d_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic        kind,
    input  wire logic [15:0] pixel,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        result_valid,
    input  wire logic [15:0] blurred,
    input  wire logic        last,
    output int               fail_count,
    output int               pending
);
    import sgb_pkg::*;

    localparam bit KIND_LOAD = 1'b0;

    typedef struct packed
    {
        logic [15:0] blurred;
        logic        last;
    } blur_result_t;

    logic [15:0]  frame_pix [MaxRows * MaxCols];
    logic [23:0]  row_sums  [MaxRows * MaxCols];
    int           load_r, load_c, fetch_r, fetch_c;
    bit           ready;
    logic [8:0]   rows_reg, cols_reg;
    logic [2:0]   rad_reg;
    logic [15:0]  taps [TapCount];
    blur_result_t expected_blurs [$];

    assign pending = expected_blurs.size();

    function automatic int eff_dim(logic [8:0] v, int maxv);
        if (v < 1) return 1;
        if (v > maxv) return maxv;
        return int'(v);
    endfunction

    function automatic int eff_radius(int dim);
        int r;
        r = int'(rad_reg);
        if (r > MaxRadius) r = MaxRadius;
        if (r > TapCount - 1) r = TapCount - 1;
        if (r > dim - 1) r = dim - 1;
        return r;
    endfunction

    function automatic int reflect(int p, int dim);
        if (p < 0) p = -p;
        if (p >= dim) p = 2 * dim - 2 - p;
        if (p < 0) p = 0;
        if (p >= dim) p = dim - 1;
        return p;
    endfunction

    task automatic filter_row(int r);
        int cols;
        int rad;
        longint unsigned acc;
        longint unsigned v;
        cols = eff_dim(cols_reg, MaxCols);
        rad = eff_radius(cols);
        for (int c = 0; c < cols; c++)
        begin
            acc = 0;
            for (int k = -rad; k <= rad; k++)
                acc += longint'(frame_pix[r * MaxCols + reflect(c + k, cols)])
                       * longint'(taps[k < 0 ? -k : k]);
            v = (acc + 64) >> 7;
            if (v > 64'hFF_FFFF) v = 64'hFF_FFFF;
            row_sums[r * MaxCols + c] = v[23:0];
        end
    endtask

    function automatic logic [15:0] filter_column(int r, int c);
        int rows;
        int rad;
        longint unsigned acc;
        rows = eff_dim(rows_reg, MaxRows);
        rad = eff_radius(rows);
        acc = 0;
        for (int k = -rad; k <= rad; k++)
            acc += longint'(row_sums[reflect(r + k, rows) * MaxCols + c])
                   * longint'(taps[k < 0 ? -k : k]);
        acc = (acc + (64'd1 << 22)) >> 23;
        if (acc > 64'hFFFF) acc = 64'hFFFF;
        return acc[15:0];
    endfunction

    task automatic predict_item(logic k, logic [15:0] p);
        int rows;
        int cols;
        blur_result_t e;
        rows = eff_dim(rows_reg, MaxRows);
        cols = eff_dim(cols_reg, MaxCols);
        if (k == KIND_LOAD)
        begin
            if (ready) return;
            if (load_r >= rows) load_r = rows - 1;
            if (load_c >= cols) load_c = cols - 1;
            frame_pix[load_r * MaxCols + load_c] = p;
            load_c++;
            if (load_c >= cols)
            begin
                filter_row(load_r);
                load_c = 0;
                load_r++;
                if (load_r >= rows)
                begin
                    load_r = 0;
                    ready = 1'b1;
                end
            end
            return;
        end
        if (!ready) return;
        if (fetch_r >= rows) fetch_r = rows - 1;
        if (fetch_c >= cols) fetch_c = cols - 1;
        e.blurred = filter_column(fetch_r, fetch_c);
        e.last = 1'b0;
        fetch_c++;
        if (fetch_c >= cols)
        begin
            fetch_c = 0;
            fetch_r++;
            if (fetch_r >= rows)
            begin
                e.last = 1'b1;
                fetch_r = 0;
                load_r = 0;
                load_c = 0;
                ready = 1'b0;
            end
        end
        expected_blurs.push_back(e);
    endtask

    task automatic check_result();
        blur_result_t e;
        if (expected_blurs.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected result blurred=%0d last=%0b", blurred, last);
            return;
        end
        e = expected_blurs.pop_front();
        if (e.blurred !== blurred || e.last !== last)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch: expected blurred=%0d last=%0b, got blurred=%0d last=%0b",
                         e.blurred, e.last, blurred, last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_r = 0;
            load_c = 0;
            fetch_r = 0;
            fetch_c = 0;
            ready = 1'b0;
            rows_reg = 9'd256;
            cols_reg = 9'd256;
            rad_reg = 3'd0;
            taps[0] = 16'd32768;
            for (int i = 1; i < TapCount; i++) taps[i] = 16'd0;
            expected_blurs.delete();
            fail_count = 0;
        end
        else
        begin
            // compare before predicting, so a fetch taken on this edge
            // cannot match a result that was already on the ports
            if (result_valid) check_result();
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_ROWS: rows_reg = cfg_data[8:0];
                    CFG_COLS: cols_reg = cfg_data[8:0];
                    CFG_RAD:  rad_reg  = cfg_data[2:0];
                    default:  taps[cfg_index - CFG_TAP0] = cfg_data;
                endcase
            end
            if (start && !busy) predict_item(kind, pixel);
        end
    end
endmodule

@@ bench/separable_gaussian_blur_2d_tb.sv @@
// Testbench top: stimulus, configuration phases and verdict for the blur.
`timescale 1ns / 1ps
module separable_gaussian_blur_2d_tb;
    import sgb_pkg::*;

    localparam bit KIND_LOAD  = 1'b0;
    localparam bit KIND_FETCH = 1'b1;
    localparam int STALL_LIMIT = 50000;
    localparam int ITEM_TARGET = 1950;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        kind;
    logic [15:0] pixel;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        result_valid;
    logic [15:0] blurred;
    logic        last;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    int          items_sent;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    separable_gaussian_blur_2d i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .pixel        (pixel),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .blurred      (blurred),
        .last         (last)
    );

    separable_gaussian_blur_2d_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .pixel        (pixel),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .blurred      (blurred),
        .last         (last),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // Watchdog: count cycles in which no item, result or register write moves.
    // A full-width horizontal pass stays far under the limit.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Pick a sender gap: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Bias pixels toward the rails so saturation and zero paths get hit.
    function automatic logic [15:0] pick_pixel();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 16'h0000;
        if (roll == 1) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // Hold start high until the block takes the item, then maybe idle.
    task automatic send_item(logic k, logic [15:0] p);
        int gap;
        start <= 1'b1;
        kind  <= k;
        pixel <= p;
        do @(posedge clk); while (busy);
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            kind  <= $urandom_range(0, 1);
            pixel <= 16'($urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Drain: drop start, wait for every expected pixel, then let the block settle.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Write all registers; upper data bits are random and must be ignored.
    task automatic set_filter(logic [8:0] rows, logic [8:0] cols, logic [2:0] rad,
                              logic [15:0] t0, logic [15:0] t1, logic [15:0] t2,
                              logic [15:0] t3, logic [15:0] t4);
        write_reg(CFG_ROWS, {7'($urandom), rows});
        write_reg(CFG_COLS, {7'($urandom), cols});
        write_reg(CFG_RAD,  {13'($urandom), rad});
        write_reg(CFG_TAP0, t0);
        write_reg(CFG_TAP1, t1);
        write_reg(CFG_TAP2, t2);
        write_reg(CFG_TAP3, t3);
        write_reg(CFG_TAP4, t4);
    endtask

    // Load and drain one frame of n pixels. With noise on, sprinkle fetches
    // before the frame is ready and loads while it is ready; both do nothing.
    task automatic run_frame(int n, bit noise);
        for (int i = 0; i < n; i++)
        begin
            if (noise && $urandom_range(0, 19) == 0)
                send_item(KIND_FETCH, pick_pixel());
            send_item(KIND_LOAD, pick_pixel());
        end
        for (int i = 0; i < n; i++)
        begin
            if (noise && $urandom_range(0, 19) == 0)
                send_item(KIND_LOAD, pick_pixel());
            send_item(KIND_FETCH, pick_pixel());
        end
        items_sent += 2 * n;
        settle();
    endtask

    function automatic logic [15:0] pick_tap();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 16'd0;
        if (roll == 1) return 16'd32768;
        if (roll == 2) return 16'hFFFF;
        if (roll < 6) return 16'($urandom);
        return 16'($urandom_range(0, 12000));
    endfunction

    initial
    begin
        int rows;
        int cols;
        int shape;
        rst_n       = 1'b0;
        start       = 1'b0;
        kind        = KIND_LOAD;
        pixel       = 16'd0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_ROWS;
        cfg_data    = 16'd0;
        idle_cycles = 0;
        items_sent  = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A fetch before any frame gives nothing.
        send_item(KIND_FETCH, 16'hFFFF);
        settle();
        // Bypass on a 2x2 frame with rail pixels.
        set_filter(9'd2, 9'd2, 3'd0, 16'd32768, 16'd0, 16'd0, 16'd0, 16'd0);
        run_frame(4, 1'b1);
        // Zero dimensions act as one: single-pixel frame.
        set_filter(9'd0, 9'd0, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_frame(1, 1'b0);
        // Oversized radius saturates, full taps saturate the intermediate.
        set_filter(9'd3, 9'd5, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_frame(15, 1'b0);
        // Radius clamped by a two-row frame, mirror on both edges.
        set_filter(9'd2, 9'd9, 3'd4, 16'd13000, 16'd7000, 16'd2000, 16'd400, 16'd40);
        run_frame(18, 1'b1);

        // Random frames: mostly small shapes, a few full-width or full-height.
        while (items_sent < ITEM_TARGET)
        begin
            shape = $urandom_range(0, 29);
            if (shape == 0)
            begin
                rows = 1;
                cols = ($urandom_range(0, 1) != 0) ? 256 : 511;
            end
            else if (shape == 1)
            begin
                rows = ($urandom_range(0, 1) != 0) ? 256 : 300;
                cols = 1;
            end
            else
            begin
                rows = $urandom_range(0, 7);
                cols = $urandom_range(0, 7);
            end
            set_filter(9'(rows), 9'(cols), 3'($urandom_range(0, 7)), pick_tap(),
                       pick_tap(), pick_tap(), pick_tap(), pick_tap());
            rows = (rows < 1) ? 1 : ((rows > MaxRows) ? MaxRows : rows);
            cols = (cols < 1) ? 1 : ((cols > MaxCols) ? MaxCols : cols);
            run_frame(rows * cols, 1'b1);
        end

        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
